// ===== hw/rtl/per_index_ema_tracker_macros.svh =====
// Assertion macros shared by the per-index EMA tracker RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef PER_INDEX_EMA_TRACKER_MACROS_SVH
`define PER_INDEX_EMA_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIET_ASSERT_HOLDS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIET_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/piet_pkg.sv =====
// Shared types and constants for the per-index EMA tracker.
// Used by piet_cell, piet_blend and per_index_ema_tracker; depends on nothing.
package piet_pkg;

  // One table entry: a signed Q16.16 value and its explored mark.
  typedef struct packed {
    logic signed [31:0] value;
    logic               mark;
  } entry_t;

  // Operation codes of a request.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Register index of the smoothing weight (address bit 2 selects the register).
  localparam logic REG_SMOOTHING_WEIGHT = 1'b0;

  // Fixed-point constants.
  localparam logic        [16:0] ALPHA_ONE   = 17'h1_0000;
  localparam logic        [16:0] WEIGHT_RST  = 17'h0_8000;
  localparam logic signed [31:0] VAL_ONE     = 32'sh0001_0000;
  localparam logic signed [31:0] VAL_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] BONUS_LIMIT = 32'sh7FFE_FFFF;

endpackage

// ===== hw/rtl/piet_cell.sv =====
// One cell of the entry ring: holds a value and its explored mark.
// Depends on piet_pkg for entry_t and the reset value.
module piet_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  piet_pkg::entry_t d,
  output piet_pkg::entry_t q
);
  import piet_pkg::*;

  // Take the neighbor's entry on every ring step; reset to 1.0, unexplored.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.value <= VAL_ONE;
      q.mark  <= 1'b0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/piet_blend.sv =====
// Two-stage blend unit: old*alpha + (1-alpha)*sample, rounded and clamped.
// Depends on piet_pkg for the fixed-point constants.
module piet_blend (
  input  logic               clk,
  input  logic signed [31:0] old_value,
  input  logic signed [31:0] sample_value,
  input  logic        [16:0] alpha,
  output logic signed [31:0] result
);
  import piet_pkg::*;

  localparam logic signed [49:0] ROUND_HALF = 50'sd32768;
  localparam logic signed [49:0] SAT_HI     = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO     = -50'sd2147483648;

  logic        [16:0] beta;
  logic signed [49:0] prod_old;
  logic signed [49:0] prod_smp;
  logic signed [49:0] rounded;

  // Weight of the sample is one minus alpha.
  assign beta = ALPHA_ONE - alpha;

  // First stage: the two products, exact in Q16.32.
  always_ff @(posedge clk) begin
    prod_old <= 50'(old_value) * 50'($signed({1'b0, alpha}));
    prod_smp <= 50'(sample_value) * 50'($signed({1'b0, beta}));
  end

  // Add one half and floor, so ties round toward positive infinity.
  assign rounded = (prod_old + prod_smp + ROUND_HALF) >>> 16;

  // Second stage: clamp to the signed 32-bit range.
  always_ff @(posedge clk) begin
    if (rounded > SAT_HI) begin
      result <= VAL_MAX;
    end else if (rounded < SAT_LO) begin
      result <= VAL_MIN;
    end else begin
      result <= rounded[31:0];
    end
  end

endmodule

// ===== hw/rtl/per_index_ema_tracker.sv =====
// Per-index EMA tracker: a ring of NUM_ENTRIES cells, each with a Q16.16 value and an
// explored mark, rotated one place per cycle past a single head position while a request
// walks it and neither the blend unit nor a stalled output holds it. An update request
// walks the ring once, holding it at the target entry while the blend unit runs when
// that entry is already explored, and then returns to idle, where the next request is
// taken. A query request walks the ring once to find the maximum, forms the bonus value,
// then walks it again emitting one result per cycle while the output side takes them.
// One request is in flight at a time; the output register lets the next request start
// while the final result still waits.
`include "per_index_ema_tracker_macros.svh"

module per_index_ema_tracker #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Request channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic        [3:0]  entry_index,
  input  logic signed [31:0] sample_value,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [3:0]  out_index,
  output logic signed [31:0] out_value,
  output logic               last_entry,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  import piet_pkg::*;

  localparam int PW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = (PW > 4) ? PW : 4;
  localparam logic [PW-1:0] LAST_POS = PW'(NUM_ENTRIES - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SEEK  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_MAX   = 7'b0010000,
    ST_BONUS = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t             state;
  logic [PW-1:0]      pos;
  logic               hit_done;
  logic               blend_ready;
  logic               all_acc;
  logic               all_explored;
  logic [16:0]        weight;
  logic [16:0]        alpha;
  logic [3:0]         idx_r;
  logic signed [31:0] sample_r;
  logic signed [31:0] mx;
  logic signed [31:0] bonus;
  logic signed [31:0] blend_q;
  entry_t             cells_q [NUM_ENTRIES];
  entry_t             head;
  entry_t             head_new;
  logic [NUM_ENTRIES-1:0] marks;
  logic               shift;
  logic               hit;
  logic               out_load;
  logic               in_range;
  logic               cfg_write;
  logic [CW-1:0]      pos_w;

  // Register access: one register, selected by address bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_SMOOTHING_WEIGHT) ? {15'b0, weight} : '0;

  // A weight above one is used as one.
  assign alpha = (weight > ALPHA_ONE) ? ALPHA_ONE : weight;

  assign in_stall = (state != ST_IDLE);
  assign in_range = 32'(entry_index) < 32'(NUM_ENTRIES);
  assign out_load = !out_valid || !out_stall;
  assign pos_w    = CW'(pos);
  assign head     = cells_q[0];
  assign hit      = (pos_w == CW'(idx_r)) && !hit_done;

  // The ring of cells: each cell takes its upper neighbor, the last takes the head.
  genvar gi;
  generate
    for (gi = 0; gi < NUM_ENTRIES; gi++) begin : g_cell
      if (gi == NUM_ENTRIES - 1) begin : g_tail
        piet_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .d     (head_new),
          .q     (cells_q[gi])
        );
      end else begin : g_body
        piet_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .d     (cells_q[gi+1]),
          .q     (cells_q[gi])
        );
      end
      assign marks[gi] = cells_q[gi].mark;
    end
  endgenerate

  // Blend of the head entry with the captured sample.
  piet_blend u_blend (
    .clk          (clk),
    .old_value    (head.value),
    .sample_value (sample_r),
    .alpha        (alpha),
    .result       (blend_q)
  );

  // Ring step and the entry written back at the head.
  always_comb begin
    shift    = 1'b0;
    head_new = head;
    case (state)
      ST_SEEK: begin
        if (!hit) begin
          shift = 1'b1;
        end else if (!head.mark) begin
          head_new.value = sample_r;
          head_new.mark  = 1'b1;
          shift          = 1'b1;
        end else if (blend_ready) begin
          head_new.value = blend_q;
          head_new.mark  = 1'b1;
          shift          = 1'b1;
        end
      end
      ST_MAX:  shift = 1'b1;
      ST_EMIT: shift = out_load;
      default: shift = 1'b0;
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pos          <= '0;
      hit_done     <= 1'b0;
      blend_ready  <= 1'b0;
      all_acc      <= 1'b1;
      all_explored <= 1'b0;
      weight       <= WEIGHT_RST;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == REG_SMOOTHING_WEIGHT)) begin
        weight <= pwdata[16:0];
      end
      if (out_load) begin
        out_valid <= (state == ST_EMIT);
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (op == OP_QUERY) begin
              state <= ST_MAX;
            end else if (in_range) begin
              state       <= ST_SEEK;
              hit_done    <= 1'b0;
              blend_ready <= 1'b0;
              all_acc     <= 1'b1;
            end
          end
        end
        ST_SEEK: begin
          if (shift) begin
            all_acc <= all_acc & head_new.mark;
            if (hit) begin
              hit_done <= 1'b1;
            end
            if (pos == LAST_POS) begin
              state        <= ST_IDLE;
              pos          <= '0;
              all_explored <= all_acc & head_new.mark;
            end else begin
              pos <= pos + 1'b1;
            end
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_SUM;
        ST_SUM: begin
          state       <= ST_SEEK;
          blend_ready <= 1'b1;
        end
        ST_MAX: begin
          if (pos == LAST_POS) begin
            state <= ST_BONUS;
            pos   <= '0;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        ST_BONUS: state <= ST_EMIT;
        ST_EMIT: begin
          if (shift) begin
            if (pos == LAST_POS) begin
              state <= ST_IDLE;
              pos   <= '0;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Captured request fields, the running maximum, the bonus and the result register.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      idx_r    <= entry_index;
      sample_r <= sample_value;
    end
    if (state == ST_MAX && (pos == '0 || head.value > mx)) begin
      mx <= head.value;
    end
    if (state == ST_BONUS) begin
      bonus <= (mx > BONUS_LIMIT) ? VAL_MAX : mx + VAL_ONE;
    end
    if (state == ST_EMIT && out_load) begin
      out_index  <= pos_w[3:0];
      out_value  <= (!all_explored && !head.mark) ? bonus : head.value;
      last_entry <= (pos == LAST_POS);
    end
  end

  // The ring is back in place whenever the sequencer rests.
  `PIET_ASSERT_HOLDS(a_idle_aligned, state == ST_IDLE, pos == '0,
                     "ring not aligned while idle")
  // The all-explored flag never runs ahead of the marks held in the cells.
  `PIET_ASSERT_HOLDS(a_flag_marks, all_explored, &marks,
                     "all_explored set with an unexplored entry")
  // While emitting, the ring steps exactly when the result register loads.
  `PIET_ASSERT_HOLDS(a_emit_step, state == ST_EMIT, shift == out_load,
                     "ring step out of step with result register")
  // A query request starts the maximum pass from the first entry.
  `PIET_ASSERT_NEXT(a_query_start, state == ST_IDLE && in_valid && op == OP_QUERY,
                    state == ST_MAX && pos == '0, "query did not start the maximum pass")

endmodule
